// File: src/dmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmv_pkg
// Shared widths, codes and types of the dense matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package dmv_pkg;

    localparam int DIM_W       = 13;
    localparam int IDX_W       = 12;
    localparam int ROW_W       = 12;
    localparam int ACC_W       = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

    typedef struct packed {
        logic first;
        logic end_row;
        logic last;
    } t_row_ctl;

endpackage

// File: src/dmv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmv_queue
// Small register queue between the front and the back part.
// ----------------------------------------------------------------------------
module dmv_queue
    import dmv_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_data,
    output logic [QLVL_W-1:0] o_level
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [QLVL_W-1:0] r_count;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_level = r_count;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !w_pop |-> r_count < QLVL_W'(QUEUE_DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

endmodule

// File: src/dmv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmv_front
// Accepts items, keeps the vector store and the row and column positions,
// and hands each matrix item with its vector entry to the queue.
// ----------------------------------------------------------------------------
module dmv_front
    import dmv_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int ELEMENT_WIDTH = 16,
    parameter int AW            = $clog2(MAX_DIMENSION)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic                            i_func,
    input  logic [IDX_W-1:0]                i_vector_index,
    input  logic signed [ELEMENT_WIDTH-1:0] i_element_value,
    input  logic [DIM_W-1:0]                i_dimension,
    input  logic [QLVL_W-1:0]               i_q_level,
    output logic                            o_s1_valid,
    output logic [ELEMENT_WIDTH-1:0]        o_s1_elem,
    output logic [ELEMENT_WIDTH-1:0]        o_s1_vec,
    output t_row_ctl                        o_s1_ctl,
    output logic [AW-1:0]                   o_s1_row
);

    localparam int NW = $clog2(MAX_DIMENSION + 1);

    logic [ELEMENT_WIDTH-1:0] r_store [MAX_DIMENSION];
    logic [ELEMENT_WIDTH-1:0] r_rd_data;
    logic [ELEMENT_WIDTH-1:0] r_s1_elem;
    t_row_ctl                 r_s1_ctl;
    logic [AW-1:0]            r_s1_row;
    logic                     r_s1_valid;
    logic [AW-1:0]            r_col;
    logic [AW-1:0]            r_row;

    logic          w_accept;
    logic          w_load;
    logic          w_idx_ok;
    logic [AW-1:0] w_wr_addr;
    logic [NW-1:0] w_n;
    logic          w_col_end;
    logic          w_row_end;

    always_comb begin
        if (i_dimension == '0) begin
            w_n = NW'(1);
        end else if (32'(i_dimension) > 32'(MAX_DIMENSION)) begin
            w_n = NW'(MAX_DIMENSION);
        end else begin
            w_n = NW'(i_dimension);
        end
    end

    assign o_full    = ({1'b0, i_q_level} + {{QLVL_W{1'b0}}, r_s1_valid})
                       >= (QLVL_W + 1)'(QUEUE_DEPTH);
    assign w_accept  = i_push && !o_full;
    assign w_load    = (i_func == FUNC_LOAD);
    assign w_idx_ok  = 32'(i_vector_index) < 32'(MAX_DIMENSION);
    assign w_wr_addr = AW'(i_vector_index);
    assign w_col_end = (32'(r_col) + 32'd1) >= 32'(w_n);
    assign w_row_end = (32'(r_row) + 32'd1) >= 32'(w_n);

    always_ff @(posedge i_clk) begin
        if (w_accept && w_load && w_idx_ok) begin
            r_store[w_wr_addr] <= i_element_value;
        end
        if (w_accept) begin
            r_rd_data <= r_store[r_col];
            r_s1_elem <= i_element_value;
            r_s1_row  <= r_row;
            r_s1_ctl  <= '{first: (r_col == '0), end_row: w_col_end,
                           last: w_col_end && w_row_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_s1_valid <= w_accept && !w_load;
            if (w_accept) begin
                if (w_load) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (!w_col_end) begin
                    r_col <= r_col + 1'b1;
                end else begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : r_row + 1'b1;
                end
            end
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_elem  = r_s1_elem;
    assign o_s1_vec   = r_rd_data;
    assign o_s1_ctl   = r_s1_ctl;
    assign o_s1_row   = r_s1_row;

    a_load_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_load |=> r_col == '0 && r_row == '0 && !r_s1_valid)
        else $error("load item did not rewind positions");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> i_q_level < QLVL_W'(QUEUE_DEPTH))
        else $error("matrix item handed over with no queue room");

endmodule

// File: src/dmv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmv_back
// Multiplies each matrix item by its vector entry, accumulates the row and
// holds each finished row sum in the output register.
// ----------------------------------------------------------------------------
module dmv_back
    import dmv_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 16,
    parameter int AW            = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  logic [ELEMENT_WIDTH-1:0] i_q_elem,
    input  logic [ELEMENT_WIDTH-1:0] i_q_vec,
    input  t_row_ctl                 i_q_ctl,
    input  logic [AW-1:0]            i_q_row,
    output logic                     o_q_pop,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic [ROW_W-1:0]         o_row_number,
    output logic signed [ACC_W-1:0]  o_row_sum,
    output logic                     o_last_row
);

    localparam int PW = 2 * ELEMENT_WIDTH;

    logic                    r_p_valid;
    logic signed [PW-1:0]    r_prod;
    t_row_ctl                r_p_ctl;
    logic [AW-1:0]           r_p_row;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_out_valid;
    logic [ROW_W-1:0]        r_out_row;
    logic [ACC_W-1:0]        r_out_sum;
    logic                    r_out_last;

    logic             w_adv;
    logic             w_fire;
    logic [ACC_W-1:0] w_base;
    logic [ACC_W-1:0] w_sum;

    assign w_adv   = !(r_p_valid && r_p_ctl.end_row && r_out_valid && !i_pop);
    assign w_fire  = w_adv && r_p_valid;
    assign o_q_pop = i_q_valid && w_adv;
    assign w_base  = r_p_ctl.first ? '0 : r_acc;
    assign w_sum   = w_base + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prod  <= $signed(i_q_elem) * $signed(i_q_vec);
            r_p_ctl <= i_q_ctl;
            r_p_row <= i_q_row;
        end
        if (w_fire && r_p_ctl.end_row) begin
            r_out_row  <= ROW_W'(r_p_row);
            r_out_sum  <= w_sum;
            r_out_last <= r_p_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_p_valid <= i_q_valid;
            end
            if (w_fire) begin
                r_acc <= w_sum;
            end
            if (w_fire && r_p_ctl.end_row) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_row_number = r_out_row;
    assign o_row_sum    = $signed(r_out_sum);
    assign o_last_row   = r_out_last;

    a_stall_only_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> r_out_valid && r_p_valid)
        else $error("back part stalled without a waiting result");

endmodule

// File: src/dense_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply_unit
// y = A * x in signed Q2.14 with a Q20.28 row accumulator. Load items fill
// the vector store, matrix items stream row-major, one result per row.
//
//   Channel   Handshake             Payload
//   input     push / full           i_func, i_vector_index, i_element_value
//   result    empty / pop           o_row_number, o_row_sum, o_last_row
//   config    i_cfg_we              i_cfg_wdata (dimension)
//
// One item per cycle sustained while full is low; a row result is registered
// after its last element passes the store read, queue, multiply and accumulate.
// Synchronous active-low reset clears positions, queue and valid flags;
// the vector store is not cleared.
// full rises when the 4-entry queue and the store-read stage hold 4 items;
// a result left waiting stalls the accumulator only at the next row end.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply_unit
    import dmv_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_func,
    input  logic [IDX_W-1:0]                i_vector_index,
    input  logic signed [ELEMENT_WIDTH-1:0] i_element_value,
    output logic                            empty,
    input  logic                            pop,
    output logic [ROW_W-1:0]                o_row_number,
    output logic signed [ACC_W-1:0]         o_row_sum,
    output logic                            o_last_row,
    input  logic                            i_cfg_we,
    input  logic [DIM_W-1:0]                i_cfg_wdata
);

    localparam int AW = $clog2(MAX_DIMENSION);
    localparam int CW = $bits(t_row_ctl);
    localparam int QW = 2 * ELEMENT_WIDTH + CW + AW;

    logic [DIM_W-1:0] r_dimension;

    logic                     w_s1_valid;
    logic [ELEMENT_WIDTH-1:0] w_s1_elem;
    logic [ELEMENT_WIDTH-1:0] w_s1_vec;
    t_row_ctl                 w_s1_ctl;
    logic [AW-1:0]            w_s1_row;

    logic                     w_q_valid;
    logic [QW-1:0]            w_q_data;
    logic [QLVL_W-1:0]        w_q_level;
    logic                     w_q_pop;
    logic [ELEMENT_WIDTH-1:0] w_q_elem;
    logic [ELEMENT_WIDTH-1:0] w_q_vec;
    t_row_ctl                 w_q_ctl;
    logic [AW-1:0]            w_q_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= DIM_W'(1);
        end else if (i_cfg_we) begin
            r_dimension <= i_cfg_wdata;
        end
    end

    dmv_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .AW            (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_func          (i_func),
        .i_vector_index  (i_vector_index),
        .i_element_value (i_element_value),
        .i_dimension     (r_dimension),
        .i_q_level       (w_q_level),
        .o_s1_valid      (w_s1_valid),
        .o_s1_elem       (w_s1_elem),
        .o_s1_vec        (w_s1_vec),
        .o_s1_ctl        (w_s1_ctl),
        .o_s1_row        (w_s1_row)
    );

    dmv_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_s1_valid),
        .i_data  ({w_s1_elem, w_s1_vec, w_s1_ctl, w_s1_row}),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_level (w_q_level)
    );

    assign {w_q_elem, w_q_vec, w_q_ctl, w_q_row} = w_q_data;

    dmv_back #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .AW            (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_elem     (w_q_elem),
        .i_q_vec      (w_q_vec),
        .i_q_ctl      (w_q_ctl),
        .i_q_row      (w_q_row),
        .o_q_pop      (w_q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_row_number (o_row_number),
        .o_row_sum    (o_row_sum),
        .o_last_row   (o_last_row)
    );

endmodule
